// ===== rtl/mlfe_pkg.sv =====
// mlfe_pkg: command codes, queued operation type and merge helper for the
// page-organised LCD framebuffer engine. No dependencies.
`default_nettype none

package mlfe_pkg;

   // Command codes on the request channel
   localparam logic [3:0] CMD_SET        = 4'd0;
   localparam logic [3:0] CMD_CLR        = 4'd1;
   localparam logic [3:0] CMD_INV        = 4'd2;
   localparam logic [3:0] CMD_CLR_ALL    = 4'd3;
   localparam logic [3:0] CMD_PASTE_OR   = 4'd4;
   localparam logic [3:0] CMD_PASTE_ANDN = 4'd5;
   localparam logic [3:0] CMD_PASTE_XOR  = 4'd6;
   localparam logic [3:0] CMD_FLUSH      = 4'd7;
   localparam logic [3:0] CMD_TICK       = 4'd8;

   // Widest store address over the supported geometry (256 x 16 pages)
   localparam int ADDR_W_MAX = 12;

   // Display controller command bytes
   localparam logic [7:0] PAGE_CMD = 8'hB0;
   localparam logic [7:0] COLH_CMD = 8'h10;

   typedef enum logic [1:0] {
      K_EDIT,
      K_CLEAR,
      K_FLUSH,
      K_TICK
   } kind_type;

   typedef enum logic [1:0] {
      M_OR,
      M_ANDN,
      M_XOR
   } merge_type;

   // One classified operation, as held in the queue
   typedef struct packed {
      kind_type                kind;
      merge_type               merge;
      logic [ADDR_W_MAX-1:0]   addr;
      logic [7:0]              mask;
      logic [2:0]              p0;
      logic [2:0]              p1;
      logic [7:0]              c0;
      logic [7:0]              c1;
   } op_type;

   function automatic logic [7:0] merge_byte(merge_type m, logic [7:0] d,
                                             logic [7:0] mask);
      logic [7:0] r;
      case (m)
         M_OR:    r = d | mask;
         M_ANDN:  r = d & ~mask;
         M_XOR:   r = d ^ mask;
         default: r = d;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/mlfe_ifs.sv =====
// mlfe_ifs: valid/ready channel interfaces for requests and LCD bytes.
// No dependencies.
`default_nettype none

interface mlfe_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] command;
   logic [7:0] x;
   logic [6:0] y;
   logic [9:0] byte_index;
   logic [7:0] paste_data;
   logic [2:0] page_first;
   logic [2:0] page_last;
   logic [7:0] col_first;
   logic [7:0] col_last;

   modport source (output valid, command, x, y, byte_index, paste_data,
                   page_first, page_last, col_first, col_last,
                   input ready);
   modport sink   (input valid, command, x, y, byte_index, paste_data,
                   page_first, page_last, col_first, col_last,
                   output ready);
endinterface

interface mlfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] lcd_byte;
   logic       is_data;
   logic       last;

   modport source (output valid, lcd_byte, is_data, last, input ready);
   modport sink   (input valid, lcd_byte, is_data, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/mlfe_front.sv =====
// mlfe_front: accepts requests, drops ignored ones and turns the rest into
// queued operations (address, mask, clamped flush window). Uses mlfe_pkg, mlfe_ifs.
`default_nettype none

module mlfe_front
   import mlfe_pkg::*;
#(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  logic        init_busy,
   mlfe_req_if.sink    req_ch,
   input  logic        q_full,
   output logic        q_push,
   output op_type      q_op
);

   localparam int         STORE_BYTES = COLUMNS * PAGES;
   localparam logic [7:0] COL_MAX     = 8'(COLUMNS - 1);
   localparam logic [2:0] PAGE_MAX    = 3'(PAGES - 1);

   function automatic logic [2:0] sat_page(logic [2:0] p);
      return (32'(p) >= PAGES) ? PAGE_MAX : p;
   endfunction

   function automatic logic [7:0] sat_col(logic [7:0] c);
      return (32'(c) >= COLUMNS) ? COL_MAX : c;
   endfunction

   logic                  keep;
   logic                  pix_ok;
   logic                  paste_ok;
   logic [ADDR_W_MAX-1:0] pix_addr;
   logic [2:0]            pa, pb;
   logic [7:0]            ca, cb;
   merge_type             merge;

   // Range checks and pixel byte address
   assign pix_ok   = (32'(req_ch.x) < COLUMNS) && (32'(req_ch.y) < 8 * PAGES);
   assign paste_ok = 32'(req_ch.byte_index) < STORE_BYTES;
   assign pix_addr = ADDR_W_MAX'(32'(req_ch.y[6:3]) * COLUMNS + 32'(req_ch.x));

   // Flush window: clamp, a last page of zero means one page, then order
   always_comb begin
      pa = sat_page(req_ch.page_first);
      pb = (req_ch.page_last == 3'd0) ? pa : sat_page(req_ch.page_last);
      ca = sat_col(req_ch.col_first);
      cb = sat_col(req_ch.col_last);
   end

   // Merge operator shared by pixel and paste commands
   always_comb begin
      case (req_ch.command) inside
         CMD_SET, CMD_PASTE_OR:  merge = M_OR;
         CMD_CLR, CMD_PASTE_ANDN: merge = M_ANDN;
         default:                merge = M_XOR;
      endcase
   end

   // Command decode
   always_comb begin
      q_op       = '0;
      q_op.merge = merge;
      q_op.p0    = (pb < pa) ? pb : pa;
      q_op.p1    = (pb < pa) ? pa : pb;
      q_op.c0    = (cb < ca) ? cb : ca;
      q_op.c1    = (cb < ca) ? ca : cb;
      keep       = 1'b0;
      unique case (req_ch.command) inside
         CMD_SET, CMD_CLR, CMD_INV: begin
            q_op.kind = K_EDIT;
            q_op.addr = pix_addr;
            q_op.mask = 8'd1 << req_ch.y[2:0];
            keep      = pix_ok;
         end
         CMD_CLR_ALL: begin
            q_op.kind = K_CLEAR;
            keep      = 1'b1;
         end
         CMD_PASTE_OR, CMD_PASTE_ANDN, CMD_PASTE_XOR: begin
            q_op.kind = K_EDIT;
            q_op.addr = ADDR_W_MAX'(req_ch.byte_index);
            q_op.mask = req_ch.paste_data;
            keep      = paste_ok;
         end
         CMD_FLUSH: begin
            q_op.kind = K_FLUSH;
            keep      = 1'b1;
         end
         CMD_TICK: begin
            q_op.kind = K_TICK;
            keep      = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_ch.ready = !q_full && !init_busy;
   assign q_push       = req_ch.valid && req_ch.ready && keep;

endmodule

`default_nettype wire

// ===== rtl/mlfe_queue.sv =====
// mlfe_queue: two-entry operation queue between front and back.
// Uses mlfe_pkg.
`default_nettype none

module mlfe_queue
   import mlfe_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type op_in,
   output logic   full,
   input  logic   pop,
   output logic   valid,
   output op_type op_out
);

   op_type     slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full   = count_ff == 2'd2;
   assign valid  = count_ff != 2'd0;
   assign op_out = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= op_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mlfe_back.sv =====
// mlfe_back: framebuffer store, clear sweep, read-modify-write edits and the
// flush sequencer with its output register. Uses mlfe_pkg, mlfe_ifs.
`default_nettype none

module mlfe_back
   import mlfe_pkg::*;
#(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  op_type     q_op,
   output logic       q_pop,
   output logic       init_busy,
   mlfe_rsp_if.source rsp_ch
);

   localparam int STORE_BYTES = COLUMNS * PAGES;
   localparam int AW          = $clog2(STORE_BYTES);
   localparam int CW          = $clog2(COLUMNS);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MERGE,
      ST_READ
   } state_type;

   typedef enum logic [1:0] {
      PH_PAGE,
      PH_COLH,
      PH_COLL,
      PH_DATA
   } phase_type;

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic        init_ff, init_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [AW-1:0] edit_addr_ff, edit_addr_in;
   logic [7:0]  edit_mask_ff, edit_mask_in;
   merge_type   edit_merge_ff, edit_merge_in;
   logic        flush_active_ff, flush_active_in;
   logic [2:0]  cur_page_ff, cur_page_in;
   logic [2:0]  end_page_ff, end_page_in;
   logic [CW-1:0] cur_col_ff, cur_col_in;
   logic [CW-1:0] start_col_ff, start_col_in;
   logic [CW-1:0] end_col_ff, end_col_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [7:0]  store_mem [STORE_BYTES];
   logic [7:0]  rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] data_addr;
   logic        wr_en;
   logic [7:0]  wr_data;
   logic [7:0]  start_col8;
   logic        pop;

   assign data_addr  = AW'(32'(cur_page_ff) * COLUMNS + 32'(cur_col_ff));
   assign start_col8 = 8'(start_col_ff);

   // A tick during a flush needs a free output register
   assign pop = (state_ff == ST_IDLE) && q_valid &&
                ((q_op.kind != K_TICK) || !flush_active_ff || !rsp_valid_ff);

   // Next-state logic
   always_comb begin
      state_in        = state_ff;
      phase_in        = phase_ff;
      init_in         = init_ff;
      clr_addr_in     = clr_addr_ff;
      edit_addr_in    = edit_addr_ff;
      edit_mask_in    = edit_mask_ff;
      edit_merge_in   = edit_merge_ff;
      flush_active_in = flush_active_ff;
      cur_page_in     = cur_page_ff;
      end_page_in     = end_page_ff;
      cur_col_in      = cur_col_ff;
      start_col_in    = start_col_ff;
      end_col_in      = end_col_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      rsp_byte_in     = rsp_byte_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_last_in     = rsp_last_ff;
      rd_addr         = data_addr;
      wr_en           = 1'b0;
      wr_addr         = clr_addr_ff;
      wr_data         = 8'd0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(STORE_BYTES - 1)) begin
               state_in = ST_IDLE;
               init_in  = 1'b0;
            end
         end
         ST_IDLE: begin
            if (pop) begin
               unique case (q_op.kind)
                  K_EDIT: begin
                     rd_addr       = AW'(q_op.addr);
                     edit_addr_in  = AW'(q_op.addr);
                     edit_mask_in  = q_op.mask;
                     edit_merge_in = q_op.merge;
                     state_in      = ST_MERGE;
                  end
                  K_CLEAR: begin
                     clr_addr_in = '0;
                     state_in    = ST_CLEAR;
                  end
                  K_FLUSH: begin
                     cur_page_in     = q_op.p0;
                     end_page_in     = q_op.p1;
                     start_col_in    = CW'(q_op.c0);
                     cur_col_in      = CW'(q_op.c0);
                     end_col_in      = CW'(q_op.c1);
                     phase_in        = PH_PAGE;
                     flush_active_in = 1'b1;
                  end
                  K_TICK: begin
                     if (flush_active_ff) begin
                        rsp_data_in = 1'b0;
                        rsp_last_in = 1'b0;
                        unique case (phase_ff)
                           PH_PAGE: begin
                              rsp_valid_in = 1'b1;
                              rsp_byte_in  = PAGE_CMD + 8'(cur_page_ff);
                              phase_in     = PH_COLH;
                           end
                           PH_COLH: begin
                              rsp_valid_in = 1'b1;
                              rsp_byte_in  = COLH_CMD | {4'd0, start_col8[7:4]};
                              phase_in     = PH_COLL;
                           end
                           PH_COLL: begin
                              rsp_valid_in = 1'b1;
                              rsp_byte_in  = {4'd0, start_col8[3:0]};
                              phase_in     = PH_DATA;
                           end
                           PH_DATA: state_in = ST_READ;
                           default: state_in = ST_IDLE;
                        endcase
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_MERGE: begin
            wr_en    = 1'b1;
            wr_addr  = edit_addr_ff;
            wr_data  = merge_byte(edit_merge_ff, rd_data_ff, edit_mask_ff);
            state_in = ST_IDLE;
         end
         ST_READ: begin
            // Data byte returned; step the column/page walk
            rsp_valid_in = 1'b1;
            rsp_byte_in  = rd_data_ff;
            rsp_data_in  = 1'b1;
            rsp_last_in  = 1'b0;
            state_in     = ST_IDLE;
            if (cur_col_ff >= end_col_ff) begin
               phase_in = PH_PAGE;
               if (cur_page_ff >= end_page_ff) begin
                  rsp_last_in     = 1'b1;
                  flush_active_in = 1'b0;
               end else begin
                  cur_page_in = cur_page_ff + 3'd1;
                  cur_col_in  = start_col_ff;
               end
            end else begin
               cur_col_in = cur_col_ff + CW'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         phase_ff        <= PH_PAGE;
         init_ff         <= 1'b1;
         clr_addr_ff     <= '0;
         flush_active_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         phase_ff        <= phase_in;
         init_ff         <= init_in;
         clr_addr_ff     <= clr_addr_in;
         flush_active_ff <= flush_active_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      edit_addr_ff  <= edit_addr_in;
      edit_mask_ff  <= edit_mask_in;
      edit_merge_ff <= edit_merge_in;
      cur_page_ff   <= cur_page_in;
      end_page_ff   <= end_page_in;
      cur_col_ff    <= cur_col_in;
      start_col_ff  <= start_col_in;
      end_col_ff    <= end_col_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Framebuffer store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   assign q_pop           = pop;
   assign init_busy       = init_ff;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.lcd_byte = rsp_byte_ff;
   assign rsp_ch.is_data  = rsp_data_ff;
   assign rsp_ch.last     = rsp_last_ff;

   // Write-back only follows a queue pop
   a_merge_after_pop: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MERGE |-> $past(pop))
      else $error("merge write without a popped edit");

   // Data read only launched with the output register free
   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !rsp_valid_ff)
      else $error("data byte would overwrite a pending byte");

   // Command bytes never end a flush
   a_header_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff |-> !rsp_last_ff)
      else $error("command byte marked last");

   // Nothing leaves the queue during the power-up sweep
   a_no_pop_in_init: assert property (@(posedge clock) disable iff (reset)
      init_ff |-> !pop)
      else $error("operation popped during power-up clear");

endmodule

`default_nettype wire

// ===== rtl/mono_lcd_framebuffer_engine.sv =====
// mono_lcd_framebuffer_engine: top level; front decoder, operation queue and
// store/flush back end. Uses mlfe_pkg, mlfe_ifs, mlfe_front, mlfe_queue, mlfe_back.
//
//   channel   dir  transfer when        payload
//   req_ch    in   valid && ready       command x y byte_index paste_data page/col range
//   rsp_ch    out  valid && ready       lcd_byte is_data last
//
// Pixel and paste edits are a registered read, then a write back.
// Start-flush and header bytes are set up when popped; a data byte first needs a registered read.
// Clear-all is the pop, then a sweep that zeroes one byte a cycle.
// After reset the same sweep runs with req_ch.ready low.
// A two-entry queue lets requests keep arriving while rsp_ch stalls, until it fills.
`default_nettype none

module mono_lcd_framebuffer_engine
   import mlfe_pkg::*;
#(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  logic       clock,
   input  logic       reset,
   mlfe_req_if.sink   req_ch,
   mlfe_rsp_if.source rsp_ch
);

   logic   init_busy;
   logic   q_full;
   logic   q_push;
   logic   q_valid;
   logic   q_pop;
   op_type q_op_in;
   op_type q_op_out;

   mlfe_front #(
      .COLUMNS (COLUMNS),
      .PAGES   (PAGES)
   ) u_front (
      .init_busy (init_busy),
      .req_ch    (req_ch),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_op      (q_op_in)
   );

   mlfe_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .op_in  (q_op_in),
      .full   (q_full),
      .pop    (q_pop),
      .valid  (q_valid),
      .op_out (q_op_out)
   );

   mlfe_back #(
      .COLUMNS (COLUMNS),
      .PAGES   (PAGES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_op      (q_op_out),
      .q_pop     (q_pop),
      .init_busy (init_busy),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire
